// ----- rtl/mkdr_pkg.sv -----
// ----------------------------------------------------------------------------
// mkdr_pkg: shared types and constants for the key debounce/repeat block
// Register indexes, field widths, reset values and the controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package mkdr_pkg;

  // Configuration field widths
  localparam int PRESS_W   = 8;
  localparam int LONG_W    = 16;
  localparam int REPEAT_W  = 16;
  localparam int RELEASE_W = 8;
  localparam int IDX_W     = 3;

  // Register reset values
  localparam logic [31:0]          REPEAT_EN_RESET = 32'd15;
  localparam logic [PRESS_W-1:0]   PRESS_RESET     = 8'd3;
  localparam logic [LONG_W-1:0]    LONG_RESET      = 16'd50;
  localparam logic [REPEAT_W-1:0]  REPEAT_RESET    = 16'd10;
  localparam logic [RELEASE_W-1:0] RELEASE_RESET   = 8'd3;

  // Register indexes on the configuration port
  typedef enum logic [IDX_W-1:0] {
    REG_REPEAT_EN = 3'd0,
    REG_PRESS     = 3'd1,
    REG_LONG      = 3'd2,
    REG_REPEAT    = 3'd3,
    REG_RELEASE   = 3'd4
  } cfg_idx_t;

  // Timing settings shared by every lane
  typedef struct packed {
    logic [PRESS_W-1:0]   press_ticks;
    logic [LONG_W-1:0]    long_press_ticks;
    logic [REPEAT_W-1:0]  repeat_ticks;
    logic [RELEASE_W-1:0] release_ticks;
  } tick_cfg_t;

  // Tick controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_BUSY = 1'b1
  } ctl_state_t;

endpackage

`default_nettype wire

// ----- rtl/multi_key_debounce_repeat_unit.sv -----
// ----------------------------------------------------------------------------
// multi_key_debounce_repeat_unit: multi-key debounce with auto-repeat
// One lane per key tracks hold and release counts; results merge into a mask.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one timer tick: key_levels,
//   active low. Each accepted tick yields exactly one result on the output
//   channel (out_valid/out_stall): fire_mask and any_pressed.
//   A result goes into the output register as soon as that register is free
//   when no key with repeat enabled sits past its long-press point, and
//   otherwise once each lane's serial remainder unit has also run (two bits
//   a cycle). One tick is in work at a time: the next tick is not taken
//   until the last result is in the output register. A finished result waits
//   there while the next tick is taken; a stalled output holds it, and a
//   second finished result waits in the lanes until the register frees up.
//   Configuration writes (cfg_valid/cfg_ready, always ready) are to go in
//   between ticks; the block itself does not enforce this. Reset loads the
//   default settings and clears all key state.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_key_debounce_repeat_unit
  import mkdr_pkg::*;
#(
  parameter int  NUM_KEYS    = 6,
  parameter int  COUNT_WIDTH = 16,
  localparam int CFG_DATA_W  = (NUM_KEYS > 16) ? NUM_KEYS : 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // tick input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [NUM_KEYS-1:0]   key_levels,
  // result output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [NUM_KEYS-1:0]   fire_mask,
  output logic                  any_pressed,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int VW    = (COUNT_WIDTH > LONG_W) ? COUNT_WIDTH : LONG_W;
  localparam int DIV_W = VW + (VW % 2);

  ctl_state_t          state;
  ctl_state_t          state_next;
  logic [NUM_KEYS-1:0] repeat_enable;
  tick_cfg_t           cfg;
  logic                any_held;
  logic [NUM_KEYS-1:0] lane_fire;
  logic [NUM_KEYS-1:0] lane_busy;
  logic                lanes_done;
  logic                out_free;
  logic                start;
  logic                load_out;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_enable        <= REPEAT_EN_RESET[NUM_KEYS-1:0];
      cfg.press_ticks      <= PRESS_RESET;
      cfg.long_press_ticks <= LONG_RESET;
      cfg.repeat_ticks     <= REPEAT_RESET;
      cfg.release_ticks    <= RELEASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        REG_REPEAT_EN: repeat_enable        <= cfg_data[NUM_KEYS-1:0];
        REG_PRESS:     cfg.press_ticks      <= cfg_data[PRESS_W-1:0];
        REG_LONG:      cfg.long_press_ticks <= cfg_data[LONG_W-1:0];
        REG_REPEAT:    cfg.repeat_ticks     <= cfg_data[REPEAT_W-1:0];
        REG_RELEASE:   cfg.release_ticks    <= cfg_data[RELEASE_W-1:0];
        default: ;
      endcase
    end
  end

  // One lane per key
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    mkdr_lane #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .VW          (VW),
      .DIV_W       (DIV_W)
    ) u_lane (
      .clk        (clk),
      .rst        (rst),
      .start      (start),
      .level      (key_levels[k]),
      .may_repeat (repeat_enable[k]),
      .cfg        (cfg),
      .fire       (lane_fire[k]),
      .busy       (lane_busy[k])
    );
  end

  assign lanes_done = ~|lane_busy;
  assign out_free   = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (lanes_done && out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_stall = 1'b1;
    start    = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        start    = in_valid;
      end
      ST_BUSY: begin
        load_out = lanes_done && out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the any-pressed flag on transfer
  always_ff @(posedge clk) begin
    if (start) begin
      any_held <= ~&key_levels;
    end
  end

  // Merge lane results into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      fire_mask   <= lane_fire;
      any_pressed <= any_held;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mkdr_rem.sv -----
// ----------------------------------------------------------------------------
// mkdr_rem: serial remainder unit
// Restoring division, two quotient bits per cycle; reports a zero remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module mkdr_rem
  import mkdr_pkg::*;
#(
  parameter int DIV_W = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DIV_W-1:0]    dividend,
  input  logic [REPEAT_W-1:0] divisor,
  output logic                busy,
  output logic                rem_zero
);

  localparam int CYCLES = DIV_W / 2;
  localparam int CNT_W  = $clog2(CYCLES + 1);

  logic [DIV_W-1:0]    num_sh;
  logic [REPEAT_W-1:0] rem;
  logic [REPEAT_W-1:0] divr;
  logic [CNT_W-1:0]    cnt;

  logic [REPEAT_W:0]   trial1;
  logic [REPEAT_W:0]   trial2;
  logic [REPEAT_W-1:0] rem1;
  logic [REPEAT_W-1:0] rem_next;

  // Two restoring steps per cycle
  always_comb begin
    trial1 = {rem, num_sh[DIV_W-1]};
    if (trial1 >= {1'b0, divr}) begin
      rem1 = REPEAT_W'(trial1 - {1'b0, divr});
    end else begin
      rem1 = trial1[REPEAT_W-1:0];
    end
    trial2 = {rem1, num_sh[DIV_W-2]};
    if (trial2 >= {1'b0, divr}) begin
      rem_next = REPEAT_W'(trial2 - {1'b0, divr});
    end else begin
      rem_next = trial2[REPEAT_W-1:0];
    end
  end

  // Load on start, then shift the dividend through
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(CYCLES);
    end else if (busy) begin
      busy <= (cnt != CNT_W'(1));
      cnt  <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= dividend;
      rem    <= '0;
      divr   <= divisor;
    end else if (busy) begin
      num_sh <= num_sh << 2;
      rem    <= rem_next;
    end
  end

  assign rem_zero = (rem == '0);

endmodule

`default_nettype wire

// ----- rtl/mkdr_lane.sv -----
// ----------------------------------------------------------------------------
// mkdr_lane: debounce and repeat tracker for one key
// Holds the hold/release counters and pressed flag; decides the fire bit.
// ----------------------------------------------------------------------------
`default_nettype none

module mkdr_lane
  import mkdr_pkg::*;
#(
  parameter int COUNT_WIDTH = 16,
  parameter int VW          = 16,
  parameter int DIV_W       = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      level,
  input  logic      may_repeat,
  input  tick_cfg_t cfg,
  output logic      fire,
  output logic      busy
);

  logic [COUNT_WIDTH-1:0] hold;
  logic [RELEASE_W-1:0]   rel_count;
  logic                   pressed;
  logic                   fire_imm;
  logic                   use_mod;

  logic [COUNT_WIDTH-1:0] hold_next;
  logic [RELEASE_W-1:0]   rel_count_next;
  logic                   pressed_next;
  logic                   fire_imm_next;
  logic                   use_mod_next;

  logic [COUNT_WIDTH-1:0] hold_inc;
  logic [RELEASE_W-1:0]   rel_inc;
  logic [VW-1:0]          count_ext;
  logic [VW-1:0]          press_ext;
  logic [VW-1:0]          long_ext;
  logic [DIV_W-1:0]       dividend;
  logic                   rem_zero;

  // Step the key state for one tick
  always_comb begin
    hold_inc       = hold + 1'b1;
    rel_inc        = rel_count + 1'b1;
    count_ext      = VW'(hold_inc);
    press_ext      = VW'(cfg.press_ticks);
    long_ext       = VW'(cfg.long_press_ticks);
    dividend       = DIV_W'(count_ext - long_ext);
    hold_next      = hold;
    rel_count_next = rel_count;
    pressed_next   = pressed;
    fire_imm_next  = 1'b0;
    use_mod_next   = 1'b0;
    if (!level) begin
      rel_count_next = '0;
      hold_next      = hold_inc;
      if (!pressed && count_ext == press_ext) begin
        pressed_next  = 1'b1;
        fire_imm_next = 1'b1;
      end else if (pressed && count_ext == long_ext) begin
        fire_imm_next = may_repeat;
      end else if (pressed && may_repeat && count_ext > long_ext) begin
        use_mod_next = (cfg.repeat_ticks != '0);
      end
    end else if (hold != '0 || pressed) begin
      if (rel_inc >= cfg.release_ticks) begin
        hold_next      = '0;
        rel_count_next = '0;
        pressed_next   = 1'b0;
      end else begin
        rel_count_next = rel_inc;
      end
    end else begin
      rel_count_next = '0;
    end
  end

  // Commit state on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      hold      <= '0;
      rel_count <= '0;
      pressed   <= 1'b0;
      fire_imm  <= 1'b0;
      use_mod   <= 1'b0;
    end else if (start) begin
      hold      <= hold_next;
      rel_count <= rel_count_next;
      pressed   <= pressed_next;
      fire_imm  <= fire_imm_next;
      use_mod   <= use_mod_next;
    end
  end

  // Repeat phase check past the long-press point
  mkdr_rem #(
    .DIV_W (DIV_W)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (start && use_mod_next),
    .dividend (dividend),
    .divisor  (cfg.repeat_ticks),
    .busy     (busy),
    .rem_zero (rem_zero)
  );

  assign fire = use_mod ? rem_zero : fire_imm;

endmodule

`default_nettype wire
